FILE: design/pstg_pkg.sv
// ----------------------------------------------------------------------------
// pstg_pkg
// Shared constants, register indices and the arctangent table for the
// polar stereographic grid to latitude/longitude block.
// ----------------------------------------------------------------------------
package pstg_pkg;

  localparam int MAX_POINTS_DEF = 4096;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int IDX_W   = 12;
  localparam int LAT_W   = 24;
  localparam int LON_W   = 25;
  localparam int POLE_W  = 14;
  localparam int CM_W    = 25;
  localparam int R2_W    = 40;
  localparam int CFG_W   = 40;
  localparam int CIDX_W  = 3;

  localparam int ANG_BITS     = 24;
  localparam int CORDIC_STEPS = 26;
  localparam int SQ_IN_W      = 56;
  localparam int SQ_OUT_W     = 28;
  localparam int CD_LAT       = CORDIC_STEPS + 2;
  localparam int NORM_TOP     = 29;
  localparam int CX_W         = 34;
  localparam int CZ_W         = 33;
  localparam int ANG_W        = 31;
  localparam int WIDE_W       = 36;

  localparam logic [ANG_W-1:0] DEG90 = ANG_W'(90) << ANG_BITS;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717,  32'd15018523,  32'd7509720,   32'd3754917,   32'd1877466,
    32'd938734,    32'd469367,    32'd234684,    32'd117342,    32'd58671,
    32'd29335,     32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115,       32'd57,
    32'd29
  };

  typedef enum logic [CIDX_W-1:0] {
    REG_POLE_COLUMN      = 3'd0,
    REG_POLE_ROW         = 3'd1,
    REG_NORTH_HEMISPHERE = 3'd2,
    REG_CENTRAL_MERIDIAN = 3'd3,
    REG_SCALED_RADIUS_SQ = 3'd4
  } cfg_reg_e;

endpackage

FILE: design/pstg_delay.sv
// ----------------------------------------------------------------------------
// pstg_delay
// Stall-aware shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module pstg_delay #(
  parameter int W     = 4,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);
  logic [W-1:0] sh_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sh_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        sh_q[i] <= sh_q[i-1];
      end
    end
  end

  assign q_o = sh_q[DEPTH-1];
endmodule

FILE: design/pstg_sqrt.sv
// ----------------------------------------------------------------------------
// pstg_sqrt
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module pstg_sqrt #(
  parameter int IN_W  = 56,
  parameter int OUT_W = 28
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [IN_W-1:0]  rad_i,
  output logic             valid_o,
  output logic [OUT_W-1:0] root_o
);
  logic [IN_W:0]    n_q [OUT_W];
  logic [IN_W:0]    r_q [OUT_W];
  logic [OUT_W-1:0] v_q;

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    localparam logic [IN_W:0] B = (IN_W+1)'(1) << (2 * (OUT_W - 1 - k));
    logic [IN_W:0] n_in, r_in, t, n_d, r_d;
    logic          v_in;

    if (k == 0) begin : g_first
      assign n_in = {1'b0, rad_i};
      assign r_in = '0;
      assign v_in = valid_i;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign r_in = r_q[k-1];
      assign v_in = v_q[k-1];
    end

    always_comb begin
      t = r_in + B;
      if (n_in >= t) begin
        n_d = n_in - t;
        r_d = (r_in >> 1) + B;
      end else begin
        n_d = n_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k] <= n_d;
        r_q[k] <= r_d;
      end
    end
  end

  assign valid_o = v_q[OUT_W-1];
  assign root_o  = r_q[OUT_W-1][OUT_W-1:0];
endmodule

FILE: design/pstg_cordic.sv
// ----------------------------------------------------------------------------
// pstg_cordic
// Pipelined vectoring CORDIC: atan2(y, x) in degrees for x, y >= 0, with an
// operand normalisation stage pair in front and a clamp to [0, 90] behind.
// ----------------------------------------------------------------------------
module pstg_cordic #(
  parameter int IN_W = 28
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  logic [IN_W-1:0] x_i,
  input  logic [IN_W-1:0] y_i,
  output logic valid_o,
  output logic [pstg_pkg::ANG_W-1:0] ang_o
);
  import pstg_pkg::*;

  logic [IN_W-1:0]        nx_q, ny_q;
  logic [4:0]             sh_q;
  logic                   nv_q;
  logic [4:0]             sh_d;
  logic [IN_W-1:0]        m;
  logic signed [CX_W-1:0] x_q [CORDIC_STEPS+1];
  logic signed [CX_W-1:0] y_q [CORDIC_STEPS+1];
  logic signed [CZ_W-1:0] z_q [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0]  v_q;

  always_comb begin
    m    = x_i | y_i;
    sh_d = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (m[i]) sh_d = 5'(NORM_TOP - i);
    end
    if (m == '0) sh_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= 1'b0;
      v_q  <= '0;
    end else if (en_i) begin
      nv_q <= valid_i;
      v_q  <= {v_q[CORDIC_STEPS-1:0], nv_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q   <= x_i;
      ny_q   <= y_i;
      sh_q   <= sh_d;
      x_q[0] <= CX_W'(nx_q) << sh_q;
      y_q[0] <= CX_W'(ny_q) << sh_q;
      z_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    localparam logic signed [CZ_W-1:0] A = $signed(CZ_W'(ATAN_TAB[i]));
    logic signed [CX_W-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + A;
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - A;
        end
      end
    end
  end

  logic signed [CZ_W-1:0] zf;
  assign zf = z_q[CORDIC_STEPS];

  always_comb begin
    if (zf < 0) begin
      ang_o = '0;
    end else if (zf > $signed(CZ_W'(DEG90))) begin
      ang_o = DEG90;
    end else begin
      ang_o = zf[ANG_W-1:0];
    end
  end

  assign valid_o = v_q[CORDIC_STEPS];
endmodule

FILE: design/polar_stereo_grid_to_latlon.sv
// ----------------------------------------------------------------------------
// polar_stereo_grid_to_latlon
// Maps a polar stereographic grid cell index to latitude and longitude.
//
// Usage: the slave stream takes one word per cell (column, row). The master
// stream returns one word per cell (latitude, longitude), both in degrees
// with FRAC_BITS fraction bits, in input order. The configuration channel
// writes the pole position, hemisphere, central meridian and the squared
// scaled radius; it is always ready. The user must see that it is written
// only while idle; the block itself does not enforce this. Throughput: one
// word per cycle while the master side accepts. Stages from the accepting
// edge to a valid output word: 1 offset stage loaded at that edge, 1
// distance stage, 28 square root stages, 28 CORDIC stages, 1 angle stage
// and the output register; the root bit count and CORDIC step count set them.
// Reset clears every valid bit and loads register defaults; nothing is
// held in flight. A stall on the master side freezes the whole pipeline
// and drops s_axis_tready in the same cycle, so no word is lost.
// ----------------------------------------------------------------------------
module polar_stereo_grid_to_latlon #(
  parameter int MAX_POINTS = pstg_pkg::MAX_POINTS_DEF,
  parameter int FRAC_BITS  = pstg_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // column_index[11:0], row_index[23:12]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // latitude[23:0], longitude[48:24], zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [pstg_pkg::CIDX_W-1:0] cfg_index_i,
  input  logic [pstg_pkg::CFG_W-1:0]  cfg_data_i
);
  import pstg_pkg::*;

  localparam int SH = ANG_BITS - FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] RND  = WIDE_W'(1) << SH;
  localparam logic signed [WIDE_W-1:0] HALF = WIDE_W'(180) << FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] FULL = WIDE_W'(360) << FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] D90  = WIDE_W'(DEG90);
  localparam logic [13:0] MAXM1 = 14'(MAX_POINTS - 1);

  typedef struct packed {
    logic dx_neg;
    logic dx_pos;
    logic dy_neg;
    logic pole;
  } flags_t;

  function automatic logic signed [WIDE_W-1:0] to_out(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] t;
    t = (v <<< 1) + RND;
    return t >>> (SH + 1);
  endfunction

  // configuration registers
  logic signed [POLE_W-1:0] pole_col_q, pole_row_q;
  logic                     north_q;
  logic signed [CM_W-1:0]   cm_q;
  logic [R2_W-1:0]          r2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole_col_q <= '0;
      pole_row_q <= '0;
      north_q    <= 1'b1;
      cm_q       <= '0;
      r2_q       <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_POLE_COLUMN:      pole_col_q <= cfg_data_i[POLE_W-1:0];
        REG_POLE_ROW:         pole_row_q <= cfg_data_i[POLE_W-1:0];
        REG_NORTH_HEMISPHERE: north_q    <= cfg_data_i[0];
        REG_CENTRAL_MERIDIAN: cm_q       <= cfg_data_i[CM_W-1:0];
        REG_SCALED_RADIUS_SQ: r2_q       <= cfg_data_i[R2_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage A: offsets from the pole cell
  logic [13:0]        col_c, row_c;
  logic signed [15:0] dx_q, dy_q;
  logic               va_q;

  always_comb begin
    col_c = 14'(s_axis_tdata[11:0]);
    row_c = 14'(s_axis_tdata[23:12]);
    if (col_c > MAXM1) col_c = MAXM1;
    if (row_c > MAXM1) row_c = MAXM1;
  end

  // stage B: squared distance
  logic [29:0]  d2_q;
  logic [13:0]  adx_q, ady_q;
  flags_t       fb_q;
  logic         vb_q;
  logic signed [31:0] sqx, sqy;
  assign sqx = dx_q * dx_q;
  assign sqy = dy_q * dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en) begin
      va_q <= s_axis_tvalid;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q  <= $signed({2'b0, col_c}) + 16'sd1 - 16'(pole_col_q);
      dy_q  <= $signed({2'b0, row_c}) + 16'sd1 - 16'(pole_row_q);
      d2_q  <= 30'(sqx) + 30'(sqy);
      adx_q <= dx_q[15] ? 14'(-dx_q) : dx_q[13:0];
      ady_q <= dy_q[15] ? 14'(-dy_q) : dy_q[13:0];
      fb_q.dx_neg <= dx_q < 0;
      fb_q.dx_pos <= dx_q > 0;
      fb_q.dy_neg <= dy_q < 0;
      fb_q.pole   <= (dx_q == 0) && (dy_q == 0);
    end
  end

  // square roots of distance and radius
  logic                vs_d, vs_r;
  logic [SQ_OUT_W-1:0] rd, rr;

  pstg_sqrt #(.IN_W(SQ_IN_W), .OUT_W(SQ_OUT_W)) u_sqrt_d (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vb_q),
    .rad_i(SQ_IN_W'({d2_q, 24'b0})), .valid_o(vs_d), .root_o(rd)
  );

  pstg_sqrt #(.IN_W(SQ_IN_W), .OUT_W(SQ_OUT_W)) u_sqrt_r (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vb_q),
    .rad_i(SQ_IN_W'({r2_q, 16'b0})), .valid_o(vs_r), .root_o(rr)
  );

  logic [27:0] lon_xy;
  pstg_delay #(.W(28), .DEPTH(SQ_OUT_W)) u_dly_xy (
    .clk_i, .en_i(en), .d_i({ady_q, adx_q}), .q_o(lon_xy)
  );

  flags_t fc;
  pstg_delay #(.W($bits(flags_t)), .DEPTH(SQ_OUT_W + CD_LAT)) u_dly_flags (
    .clk_i, .en_i(en), .d_i(fb_q), .q_o(fc)
  );

  // angles
  logic             vc_lat, vc_lon;
  logic [ANG_W-1:0] theta, zl;

  pstg_cordic #(.IN_W(SQ_OUT_W)) u_cordic_lat (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vs_d & vs_r),
    .x_i(rr), .y_i(rd), .valid_o(vc_lat), .ang_o(theta)
  );

  pstg_cordic #(.IN_W(SQ_OUT_W)) u_cordic_lon (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vs_d),
    .x_i(SQ_OUT_W'(lon_xy[27:14])), .y_i(SQ_OUT_W'(lon_xy[13:0])),
    .valid_o(vc_lon), .ang_o(zl)
  );

  // stage C: latitude, raw longitude
  logic signed [WIDE_W-1:0] latv, av, lat_q, lonr_q;
  flags_t                   fd_q;
  logic                     vd_q;

  always_comb begin
    latv = D90 - (WIDE_W'(theta) <<< 1);
    if (!north_q) latv = -latv;
    av = fc.dy_neg ? (D90 <<< 1) - WIDE_W'(zl) : WIDE_W'(zl);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vd_q        <= vc_lat & vc_lon;
      out_valid_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lat_q  <= to_out(latv);
      lonr_q <= to_out(av);
      fd_q   <= fc;
    end
  end

  // stage D: mirror, shift, wrap, saturate
  logic signed [WIDE_W-1:0] lon;
  logic signed [WIDE_W-1:0] cmw;
  logic [LAT_W-1:0]         lat_out_q;
  logic [LON_W-1:0]         lon_out_q;

  assign cmw = WIDE_W'(cm_q);

  always_comb begin
    lon = lonr_q;
    if ((fd_q.dx_neg && north_q) || (fd_q.dx_pos && !north_q)) lon = FULL - lon;
    lon = lon + cmw;
    if (lon > HALF) lon = lon - FULL;
    if (fd_q.pole) lon = cmw;
    if (lon > HALF) lon = HALF;
    if (lon < -HALF) lon = -HALF;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lat_out_q <= lat_q[LAT_W-1:0];
      lon_out_q <= lon[LON_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, lon_out_q, lat_out_q};
endmodule
